// File: sv/vsa_pkg.sv
// vsa_pkg: constants, coefficient table and side-band word types for the
// signed vector angle pipeline. No dependencies.
package vsa_pkg;

    // unity in Q1.30 and pi in Q2.30
    localparam logic [30:0]        Q30_ONE   = 31'd1073741824;
    localparam logic signed [33:0] PI_Q30    = 34'sd3373259426;
    localparam logic [15:0]        ANGLE_MAX = 16'd12868;

    // acos(x) = sqrt(1-x) * poly(x), coefficients in Q2.30, a0 first
    localparam logic signed [32:0] ACOS_COEF [0:7] = '{
        33'sd1686629690, -33'sd230423709, 33'sd95540460, -33'sd53874249,
        33'sd33169905, -33'sd18348235, 33'sd7161955, -33'sd1355590
    };

    // side words carried alongside the iterative units
    typedef struct packed {
        logic        neg;
        logic        dneg;
        logic [31:0] dmag;
    } norm_side_t;

    typedef struct packed {
        logic neg;
        logic dneg;
        logic szero;
    } div_side_t;

    typedef struct packed {
        logic neg;
        logic dneg;
    } poly_side_t;

    typedef struct packed {
        logic               neg;
        logic               dneg;
        logic signed [32:0] p;
    } root_side_t;

endpackage

// File: sv/vsa_isqrt_pipe.sv
// vsa_isqrt_pipe: pipelined floor square root, one result bit per stage,
// with a side word travelling alongside. Uses no package.
module vsa_isqrt_pipe #(
    parameter int W  = 64,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_vld,
    input  logic [W-1:0]    in_rad,
    input  logic [SW-1:0]   in_side,
    output logic            out_vld,
    output logic [W/2-1:0]  out_root,
    output logic [SW-1:0]   out_side
);

    localparam int N  = W / 2;
    localparam int RW = N + 3;

    logic            vld_reg  [0:N];
    logic [N-1:0]    root_reg [0:N];
    logic [SW-1:0]   side_reg [0:N];
    logic [RW-1:0]   rem_reg  [0:N-1];
    logic [W-1:0]    rad_reg  [0:N-1];

    logic [RW-1:0]   cur      [0:N-1];
    logic [RW-1:0]   trial    [0:N-1];
    logic [RW-1:0]   rem_next [0:N-1];
    logic            ge       [0:N-1];

    // one trial subtraction per stage
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            cur[k]      = {rem_reg[k][RW-3:0], rad_reg[k][W-1:W-2]};
            trial[k]    = RW'({root_reg[k], 2'b01});
            ge[k]       = (cur[k] >= trial[k]);
            rem_next[k] = ge[k] ? (cur[k] - trial[k]) : cur[k];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_vld;
            for (int k = 0; k < N; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        rad_reg[0]  <= in_rad;
        side_reg[0] <= in_side;
        for (int k = 0; k < N; k++)
        begin
            root_reg[k+1] <= {root_reg[k][N-2:0], ge[k]};
            side_reg[k+1] <= side_reg[k];
        end
        for (int k = 0; k < N - 1; k++)
        begin
            rem_reg[k+1] <= rem_next[k];
            rad_reg[k+1] <= rad_reg[k] << 2;
        end
    end

    assign out_vld  = vld_reg[N];
    assign out_root = root_reg[N];
    assign out_side = side_reg[N];

endmodule

// File: sv/vsa_div_pipe.sv
// vsa_div_pipe: pipelined restoring divider, one quotient bit per stage,
// with a side word travelling alongside. Uses no package.
module vsa_div_pipe #(
    parameter int DW = 32,
    parameter int QW = 31,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_vld,
    input  logic [DW-1:0]   num_hi,
    input  logic [QW-1:0]   num_lo,
    input  logic [DW-1:0]   den,
    input  logic [SW-1:0]   in_side,
    output logic            out_vld,
    output logic [QW-1:0]   out_q,
    output logic [SW-1:0]   out_side
);

    logic            vld_reg  [0:QW];
    logic [QW-1:0]   q_reg    [0:QW];
    logic [SW-1:0]   side_reg [0:QW];
    logic [DW-1:0]   rem_reg  [0:QW-1];
    logic [QW-1:0]   lo_reg   [0:QW-1];
    logic [DW-1:0]   den_reg  [0:QW-1];

    logic [DW:0]     cur      [0:QW-1];
    logic [DW:0]     diff     [0:QW-1];
    logic            ge       [0:QW-1];

    // shift in one numerator bit, subtract when it fits
    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            cur[k]  = {rem_reg[k], lo_reg[k][QW-1]};
            ge[k]   = (cur[k] >= {1'b0, den_reg[k]});
            diff[k] = ge[k] ? (cur[k] - {1'b0, den_reg[k]}) : cur[k];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_vld;
            for (int k = 0; k < QW; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= num_hi;
        lo_reg[0]   <= num_lo;
        den_reg[0]  <= den;
        q_reg[0]    <= '0;
        side_reg[0] <= in_side;
        for (int k = 0; k < QW; k++)
        begin
            q_reg[k+1]    <= {q_reg[k][QW-2:0], ge[k]};
            side_reg[k+1] <= side_reg[k];
        end
        for (int k = 0; k < QW - 1; k++)
        begin
            rem_reg[k+1] <= diff[k][DW-1:0];
            lo_reg[k+1]  <= lo_reg[k] << 1;
            den_reg[k+1] <= den_reg[k];
        end
    end

    assign out_vld  = vld_reg[QW];
    assign out_q    = q_reg[QW];
    assign out_side = side_reg[QW];

endmodule

// File: sv/vsa_poly_pipe.sv
// vsa_poly_pipe: Horner evaluation of the acos polynomial in Q2.30,
// a multiply stage and a round-and-add stage per term. Depends on vsa_pkg.
module vsa_poly_pipe #(
    parameter int SW = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  logic [30:0]        in_u,
    input  logic [SW-1:0]      in_side,
    output logic               out_vld,
    output logic signed [32:0] out_p,
    output logic [30:0]        out_u,
    output logic [SW-1:0]      out_side
);

    import vsa_pkg::*;

    localparam int NT = 7;

    // add levels
    logic               vld_reg  [0:NT];
    logic signed [32:0] p_reg    [0:NT];
    logic [30:0]        u_reg    [0:NT];
    logic [SW-1:0]      side_reg [0:NT];
    // multiply levels
    logic               mvld_reg  [0:NT-1];
    logic signed [64:0] prod_reg  [0:NT-1];
    logic [30:0]        mu_reg    [0:NT-1];
    logic [SW-1:0]      mside_reg [0:NT-1];

    logic signed [64:0] rsum     [0:NT-1];

    // round half up after the shift by 30
    always_comb
    begin
        for (int k = 0; k < NT; k++)
        begin
            rsum[k] = prod_reg[k] + 65'sd536870912;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            for (int k = 0; k < NT; k++)
            begin
                mvld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_vld;
            for (int k = 0; k < NT; k++)
            begin
                mvld_reg[k]  <= vld_reg[k];
                vld_reg[k+1] <= mvld_reg[k];
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        p_reg[0]    <= ACOS_COEF[7];
        u_reg[0]    <= in_u;
        side_reg[0] <= in_side;
        for (int k = 0; k < NT; k++)
        begin
            prod_reg[k]   <= p_reg[k] * $signed({1'b0, u_reg[k]});
            mu_reg[k]     <= u_reg[k];
            mside_reg[k]  <= side_reg[k];
            p_reg[k+1]    <= $signed(rsum[k][62:30]) + ACOS_COEF[NT-1-k];
            u_reg[k+1]    <= mu_reg[k];
            side_reg[k+1] <= mside_reg[k];
        end
    end

    assign out_vld  = vld_reg[NT];
    assign out_p    = p_reg[NT];
    assign out_u    = u_reg[NT];
    assign out_side = side_reg[NT];

endmodule

// File: sv/vector3_signed_angle_top.sv
// vector3_signed_angle_top: signed angle between two 3D vectors.
// Depends on vsa_pkg, vsa_isqrt_pipe, vsa_div_pipe and vsa_poly_pipe.
//
// Usage:
//   Input word: a_x..b_z, signed Q7.8, taken at a rising edge with start high
//   and busy low. busy is always low, so a word may be offered every cycle.
//   Output word: angle_rad, signed Q2.12 radians, valid for one cycle while
//   done is high; the receiver cannot stall, so nothing holds results back.
//   Throughput: one word per cycle, results in order.
//   The latency is set by the two bit-per-stage square roots (32 and 31
//   stages), the 31-stage divider and the 14-stage Horner polynomial.
//   Reset clears every valid bit; words in flight are dropped and done
//   stays low until a new word has passed through.
//   Zero vectors give +pi/2; parallel or antiparallel vectors give 0 or pi.
module vector3_signed_angle_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] a_x,
    input  logic signed [15:0] a_y,
    input  logic signed [15:0] a_z,
    input  logic signed [15:0] b_x,
    input  logic signed [15:0] b_y,
    input  logic signed [15:0] b_z,
    output logic               done,
    output logic signed [14:0] angle_rad
);

    import vsa_pkg::*;

    // stage 1: products
    logic               s1_vld_reg;
    logic signed [31:0] dxx_reg, dyy_reg, dzz_reg;
    logic signed [31:0] aa_x_reg, aa_y_reg, aa_z_reg;
    logic signed [31:0] bb_x_reg, bb_y_reg, bb_z_reg;
    logic signed [31:0] yz_reg, zy_reg, zx_reg, xz_reg, xy_reg, yx_reg;

    // stage 2: sums
    logic               s2_vld_reg;
    logic               s2_neg_reg;
    logic signed [33:0] s2_d_reg;
    logic [31:0]        s2_na_reg, s2_nb_reg;
    logic signed [32:0] cx, cy, cz;
    logic signed [33:0] d_next;

    // stage 3: norm product and dot magnitude
    logic               s3_vld_reg;
    logic [63:0]        s3_nn_reg;
    norm_side_t         s3_side_reg;

    // first root
    logic               r1_vld;
    logic [31:0]        r1_root;
    norm_side_t         r1_side;

    // stage 4: divider numerator
    logic               s4_vld_reg;
    logic [62:0]        s4_num_reg;
    logic [31:0]        s4_s_reg;
    div_side_t          s4_side_reg;

    // divider
    logic               dv_vld;
    logic [30:0]        dv_q;
    div_side_t          dv_side;

    // stage 5: cosine magnitude
    logic               s5_vld_reg;
    logic [30:0]        s5_u_reg;
    poly_side_t         s5_side_reg;

    // polynomial
    logic               pl_vld;
    logic signed [32:0] pl_p;
    logic [30:0]        pl_u;
    poly_side_t         pl_side;
    root_side_t         pl_rside;
    logic [30:0]        one_minus_u;

    // second root
    logic               r2_vld;
    logic [30:0]        r2_root;
    root_side_t         r2_side;

    // stages 7 to 10: final product, rounding and sign
    logic               s7_vld_reg;
    logic signed [64:0] s7_tp_reg;
    poly_side_t         s7_side_reg;
    logic               s8_vld_reg;
    logic signed [33:0] s8_t_reg;
    poly_side_t         s8_side_reg;
    logic signed [64:0] t_rnd;
    logic               s9_vld_reg;
    logic signed [33:0] s9_t_reg;
    logic               s9_neg_reg;
    logic signed [33:0] t_fold;
    logic signed [33:0] a_rnd;
    logic [15:0]        ang_mag;
    logic [15:0]        ang_clip;
    logic               done_reg;
    logic signed [14:0] angle_reg;

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid chain of the local stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
            s9_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= r1_vld;
            s5_vld_reg <= dv_vld;
            s7_vld_reg <= r2_vld;
            s8_vld_reg <= s7_vld_reg;
            s9_vld_reg <= s8_vld_reg;
            done_reg   <= s9_vld_reg;
        end
    end

    // stage 1: all component products
    always_ff @(posedge clk)
    begin
        dxx_reg  <= a_x * b_x;
        dyy_reg  <= a_y * b_y;
        dzz_reg  <= a_z * b_z;
        aa_x_reg <= a_x * a_x;
        aa_y_reg <= a_y * a_y;
        aa_z_reg <= a_z * a_z;
        bb_x_reg <= b_x * b_x;
        bb_y_reg <= b_y * b_y;
        bb_z_reg <= b_z * b_z;
        yz_reg   <= a_y * b_z;
        zy_reg   <= a_z * b_y;
        zx_reg   <= a_z * b_x;
        xz_reg   <= a_x * b_z;
        xy_reg   <= a_x * b_y;
        yx_reg   <= a_y * b_x;
    end

    // stage 2: cross product signs, dot product, squared norms
    assign cx     = 33'(yz_reg) - 33'(zy_reg);
    assign cy     = 33'(zx_reg) - 33'(xz_reg);
    assign cz     = 33'(xy_reg) - 33'(yx_reg);
    assign d_next = 34'(dxx_reg) + 34'(dyy_reg) + 34'(dzz_reg);

    always_ff @(posedge clk)
    begin
        s2_neg_reg <= cx[32] | cy[32] | cz[32];
        s2_d_reg   <= d_next;
        s2_na_reg  <= $unsigned(aa_x_reg) + $unsigned(aa_y_reg) + $unsigned(aa_z_reg);
        s2_nb_reg  <= $unsigned(bb_x_reg) + $unsigned(bb_y_reg) + $unsigned(bb_z_reg);
    end

    // stage 3: product of squared norms
    always_ff @(posedge clk)
    begin
        s3_nn_reg        <= s2_na_reg * s2_nb_reg;
        s3_side_reg.neg  <= s2_neg_reg;
        s3_side_reg.dneg <= s2_d_reg[33];
        s3_side_reg.dmag <= s2_d_reg[33] ? 32'(-s2_d_reg) : s2_d_reg[31:0];
    end

    vsa_isqrt_pipe #(
        .W  (64),
        .SW ($bits(norm_side_t))
    ) u_root_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s3_vld_reg),
        .in_rad   (s3_nn_reg),
        .in_side  (s3_side_reg),
        .out_vld  (r1_vld),
        .out_root (r1_root),
        .out_side (r1_side)
    );

    // stage 4: numerator |d| * 2^30 + s/2
    always_ff @(posedge clk)
    begin
        s4_num_reg        <= 63'({r1_side.dmag, 30'd0}) + 63'(r1_root[31:1]);
        s4_s_reg          <= r1_root;
        s4_side_reg.neg   <= r1_side.neg;
        s4_side_reg.dneg  <= r1_side.dneg;
        s4_side_reg.szero <= (r1_root == '0);
    end

    vsa_div_pipe #(
        .DW (32),
        .QW (31),
        .SW ($bits(div_side_t))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s4_vld_reg),
        .num_hi   (s4_num_reg[62:31]),
        .num_lo   (s4_num_reg[30:0]),
        .den      (s4_s_reg),
        .in_side  (s4_side_reg),
        .out_vld  (dv_vld),
        .out_q    (dv_q),
        .out_side (dv_side)
    );

    // stage 5: clamp cosine to one, zero vector gives zero
    always_ff @(posedge clk)
    begin
        if (dv_side.szero)
        begin
            s5_u_reg <= '0;
        end
        else if (dv_q > Q30_ONE)
        begin
            s5_u_reg <= Q30_ONE;
        end
        else
        begin
            s5_u_reg <= dv_q;
        end
        s5_side_reg.neg  <= dv_side.neg;
        s5_side_reg.dneg <= dv_side.dneg;
    end

    vsa_poly_pipe #(
        .SW ($bits(poly_side_t))
    ) u_poly (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s5_vld_reg),
        .in_u     (s5_u_reg),
        .in_side  (s5_side_reg),
        .out_vld  (pl_vld),
        .out_p    (pl_p),
        .out_u    (pl_u),
        .out_side (pl_side)
    );

    // sqrt(1 - u) in Q1.30
    assign one_minus_u   = Q30_ONE - pl_u;
    assign pl_rside.neg  = pl_side.neg;
    assign pl_rside.dneg = pl_side.dneg;
    assign pl_rside.p    = pl_p;

    vsa_isqrt_pipe #(
        .W  (62),
        .SW ($bits(root_side_t))
    ) u_root_cos (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (pl_vld),
        .in_rad   ({1'b0, one_minus_u, 30'd0}),
        .in_side  (pl_rside),
        .out_vld  (r2_vld),
        .out_root (r2_root),
        .out_side (r2_side)
    );

    // stage 7: poly times root
    always_ff @(posedge clk)
    begin
        s7_tp_reg        <= r2_side.p * $signed({1'b0, r2_root});
        s7_side_reg.neg  <= r2_side.neg;
        s7_side_reg.dneg <= r2_side.dneg;
    end

    // stage 8: round back to Q2.30
    assign t_rnd = s7_tp_reg + 65'sd536870912;

    always_ff @(posedge clk)
    begin
        s8_t_reg    <= t_rnd[63:30];
        s8_side_reg <= s7_side_reg;
    end

    // stage 9: fold negative cosine onto pi minus angle
    assign t_fold = s8_side_reg.dneg ? (PI_Q30 - s8_t_reg) : s8_t_reg;

    always_ff @(posedge clk)
    begin
        s9_t_reg   <= t_fold[33] ? '0 : t_fold;
        s9_neg_reg <= s8_side_reg.neg;
    end

    // stage 10: round to Q2.12, clamp, apply sign
    assign a_rnd    = s9_t_reg + 34'sd131072;
    assign ang_mag  = a_rnd[33:18];
    assign ang_clip = (ang_mag > ANGLE_MAX) ? ANGLE_MAX : ang_mag;

    always_ff @(posedge clk)
    begin
        angle_reg <= s9_neg_reg ? -$signed(ang_clip[14:0]) : $signed(ang_clip[14:0]);
    end

    assign done      = done_reg;
    assign angle_rad = angle_reg;

endmodule
